// ===== hw/rtl/c3x3_pkg.sv =====
package c3x3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 8;
    localparam int KROW_W     = 24;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int N_TAPS     = 3;
    // nine products of s8 x u8 need 20 signed bits
    localparam int PSUM_W     = 20;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

    localparam logic [KROW_W-1:0]   KROW_RESET   = 24'hFF0001;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd1024;
    localparam logic [PIX_W-1:0]    PIX_MAX      = 8'd255;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    // one column of the neighbourhood, index 0 = top row
    typedef logic [N_TAPS-1:0][PIX_W-1:0] col_t;
    // one kernel column, index 0 = top row, signed bytes
    typedef logic [N_TAPS-1:0][7:0] kcol_t;

    typedef struct packed {
        col_t [N_TAPS-1:0]        cols;
        logic signed [PSUM_W-1:0] psum;
        logic                     eof;
    } job_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eof;
    } result_t;

endpackage

// ===== hw/rtl/c3x3_if.sv =====
interface c3x3_in_if;
    import c3x3_pkg::*;
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [PIX_W-1:0] pixel_in;
    modport source (output valid, output opcode, output pixel_in, input ready);
    modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

interface c3x3_out_if;
    import c3x3_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_frame;
    modport source (output valid, output pixel_out, output end_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input end_of_frame, output ready);
endinterface

interface c3x3_cfg_if;
    import c3x3_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [KROW_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/c3x3_cell.sv =====
module c3x3_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  c3x3_pkg::job_t  in_job,
    input  c3x3_pkg::kcol_t kcol,
    output logic            out_valid,
    output c3x3_pkg::job_t  out_job
);
    import c3x3_pkg::*;

    logic                       valid_reg;
    job_t                       job_reg;
    job_t                       job_next;
    logic signed [16:0]         prod [N_TAPS];
    logic signed [PSUM_W-1:0]   acc;

    // multiply-accumulate on the leading column, then rotate it to the back
    always_comb
    begin
        acc = in_job.psum;
        for (int r = 0; r < N_TAPS; r++)
        begin
            prod[r] = $signed(kcol[r]) * $signed({1'b0, in_job.cols[0][r]});
            acc     = acc + PSUM_W'(prod[r]);
        end
        job_next         = in_job;
        job_next.cols[0] = in_job.cols[1];
        job_next.cols[1] = in_job.cols[2];
        job_next.cols[2] = in_job.cols[0];
        job_next.psum    = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            job_reg <= job_next;
    end

    assign out_valid = valid_reg;
    assign out_job   = job_reg;

endmodule

// ===== hw/rtl/c3x3_line_store.sv =====
module c3x3_line_store (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [c3x3_pkg::COL_W-1:0]   rd_addr,
    input  logic                         wr_en,
    input  logic [c3x3_pkg::COL_W-1:0]   wr_addr,
    input  logic [c3x3_pkg::PIX_W-1:0]   wr_older,
    input  logic [c3x3_pkg::PIX_W-1:0]   wr_newer,
    output logic [c3x3_pkg::PIX_W-1:0]   rd_older,
    output logic [c3x3_pkg::PIX_W-1:0]   rd_newer
);
    import c3x3_pkg::*;

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_older_reg;
    logic [PIX_W-1:0] rd_newer_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
        if (rd_en)
        begin
            // same column written this edge (one-pixel rows): pass write data through
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_older_reg <= wr_older;
                rd_newer_reg <= wr_newer;
            end
            else
            begin
                rd_older_reg <= older_mem[rd_addr];
                rd_newer_reg <= newer_mem[rd_addr];
            end
        end
    end

    assign rd_older = rd_older_reg;
    assign rd_newer = rd_newer_reg;

endmodule

// ===== hw/rtl/c3x3_out_fifo.sv =====
module c3x3_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  c3x3_pkg::result_t   push_data,
    output logic                pop,
    c3x3_out_if.source          results
);
    import c3x3_pkg::*;

    result_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;

    assign results.valid        = (count_reg != '0);
    assign results.pixel_out    = entry_reg[rd_ptr_reg].pixel;
    assign results.end_of_frame = entry_reg[rd_ptr_reg].eof;
    assign pop                  = results.valid && results.ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (FIFO_AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("result queue written while full");

endmodule

// ===== hw/rtl/conv3x3_edge_replicate_clamp.sv =====
// Streaming 3x3 convolution with replicated borders and 0..255 clamping. Pixels are taken one
// per clock in raster order unless the issue stage waits for queue credit; a pixel at the
// last column of a row at least two pixels wide, from the second row on, produces two results
// and holds the input until the second is issued. Flush requests (opcode 1) drain the last row
// the same way once the whole frame is in; requests that do not fit the frame state are
// dropped. Each result runs through a three-cell multiply-accumulate chain and lands in an
// eight-entry result queue; issue into the chain waits for queue credit, which is what
// throttles the input under output back-pressure. The two line stores need no clearing after
// reset. Configuration writes are taken at once and must only be made while no request is in
// flight.
module conv3x3_edge_replicate_clamp (
    input  logic        clk,
    input  logic        rst_n,
    c3x3_in_if.sink     pixels,
    c3x3_out_if.source  results,
    c3x3_cfg_if.sink    cfg
);
    import c3x3_pkg::*;

    // configuration
    logic [KROW_W-1:0]   ktop_reg;
    logic [KROW_W-1:0]   kmid_reg;
    logic [KROW_W-1:0]   kbot_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    // raster position
    logic [HEIGHT_W-1:0] row_reg;
    logic [HEIGHT_W-1:0] row_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [COL_W-1:0]    drain_reg;
    logic [COL_W-1:0]    drain_next;

    logic [WIDTH_W-1:0]  w_eff;
    logic [COL_W-1:0]    w_last;
    logic [HEIGHT_W-1:0] h_eff;
    logic                received;
    logic                is_flush;
    logic [COL_W-1:0]    c_raw;
    logic [COL_W-1:0]    c_in;
    logic                row_end_in;
    logic                take;
    logic                accept;
    logic                load;

    // issue stage
    logic                s1_valid_reg;
    logic                s1_flush_reg;
    logic                s1_row0_reg;
    logic                s1_row_end_reg;
    logic [COL_W-1:0]    s1_c_reg;
    logic [PIX_W-1:0]    s1_px_reg;
    logic                s1_phase_reg;
    logic                s1_phase_next;
    logic [PIX_W-1:0]    older_rd;
    logic [PIX_W-1:0]    newer_rd;
    col_t                n_col;
    col_t                w0_reg;
    col_t                w3_reg;
    logic                j1;
    logic                j2;
    logic                has_job;
    logic                need_two;
    logic                second;
    logic                credit_ok;
    logic                issue;
    logic                s1_retire;
    job_t                job;

    logic [FIFO_AW:0]    resv_reg;
    logic [FIFO_AW:0]    resv_next;
    logic                pop;

    kcol_t               kcols [N_TAPS];
    logic                cv [N_TAPS+1];
    job_t                cj [N_TAPS+1];
    result_t             res;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ktop_reg   <= KROW_RESET;
            kmid_reg   <= KROW_RESET;
            kbot_reg   <= KROW_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_KERNEL_TOP:    ktop_reg   <= cfg.data;
                CFG_KERNEL_MIDDLE: kmid_reg   <= cfg.data;
                CFG_KERNEL_BOTTOM: kbot_reg   <= cfg.data;
                CFG_IMAGE_WIDTH:   width_reg  <= cfg.data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg <= cfg.data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        w_last = COL_W'(w_eff - WIDTH_W'(1));
        h_eff  = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    always_comb
    begin
        for (int k = 0; k < N_TAPS; k++)
        begin
            kcols[k][0] = ktop_reg[8*k +: 8];
            kcols[k][1] = kmid_reg[8*k +: 8];
            kcols[k][2] = kbot_reg[8*k +: 8];
        end
    end

    // ---------------------------------------------------------------- accept
    assign received   = (row_reg >= h_eff);
    assign is_flush   = (pixels.opcode == OP_FLUSH);
    assign c_raw      = is_flush ? drain_reg : col_reg;
    assign c_in       = (c_raw > w_last) ? w_last : c_raw;
    assign row_end_in = (c_in == w_last);
    assign take       = is_flush ? received : !received;

    assign pixels.ready = !s1_valid_reg || s1_retire;
    assign accept       = pixels.valid && pixels.ready;
    assign load         = accept && take;

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        drain_next = drain_reg;
        if (load)
        begin
            if (is_flush)
            begin
                if (row_end_in)
                begin
                    drain_next = '0;
                    row_next   = '0;
                    col_next   = '0;
                end
                else
                    drain_next = c_in + COL_W'(1);
            end
            else if (row_end_in)
            begin
                col_next = '0;
                row_next = row_reg + HEIGHT_W'(1);
            end
            else
                col_next = c_in + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            drain_reg <= drain_next;
        end
    end

    c3x3_line_store u_line_store (
        .clk      (clk),
        .rd_en    (load),
        .rd_addr  (c_in),
        .wr_en    (s1_retire && !s1_flush_reg),
        .wr_addr  (s1_c_reg),
        .wr_older (s1_row0_reg ? s1_px_reg : newer_rd),
        .wr_newer (s1_px_reg),
        .rd_older (older_rd),
        .rd_newer (newer_rd)
    );

    // ---------------------------------------------------------------- issue
    always_comb
    begin
        n_col[0] = older_rd;
        n_col[1] = newer_rd;
        n_col[2] = s1_flush_reg ? newer_rd : s1_px_reg;
    end

    assign j1        = (s1_c_reg != '0);
    assign j2        = s1_row_end_reg;
    assign has_job   = !s1_row0_reg && (j1 || j2);
    assign need_two  = !s1_row0_reg && j1 && j2;
    assign second    = need_two ? s1_phase_reg : !j1;
    assign credit_ok = (resv_reg < (FIFO_AW+1)'(FIFO_DEPTH));
    assign issue     = s1_valid_reg && has_job && credit_ok;
    assign s1_retire = s1_valid_reg
                       && (!has_job || (credit_ok && (!need_two || s1_phase_reg)));

    always_comb
    begin
        if (s1_retire)
            s1_phase_next = 1'b0;
        else if (issue)
            s1_phase_next = 1'b1;
        else
            s1_phase_next = s1_phase_reg;
    end

    // second result of a row end repeats the right edge
    always_comb
    begin
        job.psum = '0;
        if (second)
        begin
            job.cols[0] = (s1_c_reg == '0) ? n_col : w0_reg;
            job.cols[1] = n_col;
            job.cols[2] = n_col;
            job.eof     = s1_flush_reg;
        end
        else
        begin
            job.cols[0] = (s1_c_reg == COL_W'(1)) ? w0_reg : w3_reg;
            job.cols[1] = w0_reg;
            job.cols[2] = n_col;
            job.eof     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
            w0_reg       <= '0;
            w3_reg       <= '0;
            resv_reg     <= '0;
        end
        else
        begin
            if (load)
                s1_valid_reg <= 1'b1;
            else if (s1_retire)
                s1_valid_reg <= 1'b0;
            s1_phase_reg <= s1_phase_next;
            if (s1_retire && !s1_row0_reg)
            begin
                w3_reg <= w0_reg;
                w0_reg <= n_col;
            end
            resv_reg <= resv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_flush_reg   <= is_flush;
            s1_row0_reg    <= !is_flush && (row_reg == '0);
            s1_row_end_reg <= row_end_in;
            s1_c_reg       <= c_in;
            s1_px_reg      <= pixels.pixel_in;
        end
    end

    // queue slots held by results in the chain or waiting in the queue
    always_comb
    begin
        resv_next = resv_reg;
        if (issue && !pop)
            resv_next = resv_reg + (FIFO_AW+1)'(1);
        else if (pop && !issue)
            resv_next = resv_reg - (FIFO_AW+1)'(1);
    end

    // ---------------------------------------------------------------- MAC chain
    assign cv[0] = issue;
    assign cj[0] = job;

    for (genvar k = 0; k < N_TAPS; k++)
    begin : g_cell
        c3x3_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[k]),
            .in_job    (cj[k]),
            .kcol      (kcols[k]),
            .out_valid (cv[k+1]),
            .out_job   (cj[k+1])
        );
    end

    always_comb
    begin
        if (cj[N_TAPS].psum < 0)
            res.pixel = '0;
        else if (cj[N_TAPS].psum > PSUM_W'(PIX_MAX))
            res.pixel = PIX_MAX;
        else
            res.pixel = cj[N_TAPS].psum[PIX_W-1:0];
        res.eof = cj[N_TAPS].eof;
    end

    c3x3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cv[N_TAPS]),
        .push_data (res),
        .pop       (pop),
        .results   (results)
    );

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        resv_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("more results reserved than queue entries");

    a_chain_latency: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> ##3 cv[N_TAPS])
        else $error("issued result did not reach the queue after three cells");

    a_hold_on_double: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && need_two && !s1_phase_reg) |-> !pixels.ready)
        else $error("input taken before second row-end result issued");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import c3x3_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 250;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 200;
    localparam int SHOWN_ERRORS  = 10;

    typedef struct packed {
        opcode_t          op;
        logic [PIX_W-1:0] px;
    } raster_req_t;

    logic clk = 1'b0;
    logic rst_n;

    c3x3_in_if  pix_if ();
    c3x3_out_if res_if ();
    c3x3_cfg_if cfg_if ();

    conv3x3_edge_replicate_clamp DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_if),
        .results (res_if),
        .cfg     (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the block: registers, line stores, window, raster position
    logic [KROW_W-1:0]   kern_rows [N_TAPS];
    logic [WIDTH_W-1:0]  frame_w;
    logic [HEIGHT_W-1:0] frame_h;
    logic [PIX_W-1:0]    line_old [MAX_WIDTH];
    logic [PIX_W-1:0]    line_new [MAX_WIDTH];
    col_t                win_last;
    col_t                win_prev;
    int unsigned         row_pos;
    int unsigned         col_pos;
    int unsigned         drain_pos;
    result_t             expected_px [$];

    raster_req_t raster_reqs [$];
    raster_req_t next_req;
    result_t     out_want;
    int          reqs_left   = 0;
    int unsigned frame_reqs  = 0;
    int          err_count   = 0;
    int          cycle_count = 0;
    bit          in_taken    = 1'b0;
    bit          idle_on     = 1'b1;
    int          send_gap    = 0;
    int          stall_left  = 0;
    int          hold_ask    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;

    function automatic int unsigned eff_w();
        if (frame_w == '0)
            return 1;
        if (frame_w > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(frame_w);
    endfunction

    function automatic int unsigned eff_h();
        return (frame_h == '0) ? 1 : 32'(frame_h);
    endfunction

    function automatic logic [PIX_W-1:0] convolve(col_t lft, col_t mid, col_t rgt);
        int acc;
        acc = 0;
        for (int k = 0; k < N_TAPS; k++)
        begin
            acc += int'($signed(kern_rows[k][7:0]))   * int'(lft[k]);
            acc += int'($signed(kern_rows[k][15:8]))  * int'(mid[k]);
            acc += int'($signed(kern_rows[k][23:16])) * int'(rgt[k]);
        end
        if (acc < 0)
            return '0;
        if (acc > 255)
            return PIX_MAX;
        return acc[PIX_W-1:0];
    endfunction

    task automatic add_expected(logic [PIX_W-1:0] px, logic eof);
        result_t r;
        r.pixel = px;
        r.eof   = eof;
        expected_px.push_back(r);
    endtask

    // new column n arrives at position c; emits the output one column behind,
    // and at the row end the last column with its right edge replicated
    task automatic shift_column(int unsigned c, bit row_end, col_t n, bit last_row);
        if (c >= 1)
            add_expected(convolve((c == 1) ? win_last : win_prev, win_last, n), 1'b0);
        if (row_end)
            add_expected(convolve((c == 0) ? n : win_last, n, n), last_row);
        win_prev = win_last;
        win_last = n;
    endtask

    task automatic step_raster(opcode_t op, logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        bit          full;
        bit          row_end;
        col_t        n;
        w    = eff_w();
        h    = eff_h();
        full = (row_pos >= h);
        if (op == OP_PIXEL)
        begin
            if (!full)
            begin
                c       = (col_pos > w - 1) ? w - 1 : col_pos;
                row_end = (c == w - 1);
                if (row_pos == 0)
                begin
                    // top edge: both stores take the first row
                    line_old[c[COL_W-1:0]] = px;
                    line_new[c[COL_W-1:0]] = px;
                end
                else
                begin
                    n[0] = line_old[c[COL_W-1:0]];
                    n[1] = line_new[c[COL_W-1:0]];
                    n[2] = px;
                    shift_column(c, row_end, n, 1'b0);
                    line_old[c[COL_W-1:0]] = line_new[c[COL_W-1:0]];
                    line_new[c[COL_W-1:0]] = px;
                end
                if (row_end)
                begin
                    col_pos = 0;
                    row_pos = (row_pos + 1) & ((1 << HEIGHT_W) - 1);
                end
                else
                    col_pos = c + 1;
            end
        end
        else if (full)
        begin
            c       = (drain_pos > w - 1) ? w - 1 : drain_pos;
            row_end = (c == w - 1);
            n[0]    = line_old[c[COL_W-1:0]];
            n[1]    = line_new[c[COL_W-1:0]];
            n[2]    = line_new[c[COL_W-1:0]];
            shift_column(c, row_end, n, 1'b1);
            if (row_end)
            begin
                drain_pos = 0;
                row_pos   = 0;
                col_pos   = 0;
            end
            else
                drain_pos = c + 1;
        end
    endtask

    task automatic report_miss(string field, logic [PIX_W-1:0] want_v, logic [PIX_W-1:0] got_v);
        err_count++;
        if (err_count <= SHOWN_ERRORS)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    // sampling side: requests taken go through the predictor, results are checked
    always @(posedge clk)
    begin
        in_taken = pix_if.valid && pix_if.ready;
        if (rst_n)
        begin
            if (pix_if.valid && pix_if.ready)
            begin
                step_raster(opcode_t'(pix_if.opcode), pix_if.pixel_in);
                reqs_left--;
            end
            if (res_if.valid && res_if.ready)
            begin
                if (expected_px.size() == 0)
                    report_miss("pixel_out, nothing expected", 'x, res_if.pixel_out);
                else
                begin
                    out_want = expected_px.pop_front();
                    if (res_if.pixel_out !== out_want.pixel)
                        report_miss("pixel_out", out_want.pixel, res_if.pixel_out);
                    if (res_if.end_of_frame !== out_want.eof)
                        report_miss("end_of_frame", PIX_W'(out_want.eof),
                                    PIX_W'(res_if.end_of_frame));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pix_if.valid    <= 1'b0;
            pix_if.opcode   <= OP_PIXEL;
            pix_if.pixel_in <= '0;
        end
        else if (!pix_if.valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                pix_if.valid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 5);
                pix_if.valid <= 1'b0;
            end
            else if (raster_reqs.size() != 0)
            begin
                next_req = raster_reqs.pop_front();
                pix_if.valid    <= 1'b1;
                pix_if.opcode   <= next_req.op;
                pix_if.pixel_in <= next_req.px;
            end
            else
                pix_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (hold_seen != hold_ask)
        begin
            // long hold-off: the result queue fills and the input backs up
            hold_seen = hold_ask;
            hold_left = LONG_HOLD;
            res_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_if.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_px.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            CFG_KERNEL_TOP:    kern_rows[0] = val;
            CFG_KERNEL_MIDDLE: kern_rows[1] = val;
            CFG_KERNEL_BOTTOM: kern_rows[2] = val;
            CFG_IMAGE_WIDTH:   frame_w = val[WIDTH_W-1:0];
            CFG_IMAGE_HEIGHT:  frame_h = val[HEIGHT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic offer(opcode_t op, logic [PIX_W-1:0] px);
        raster_req_t rq;
        rq.op = op;
        rq.px = px;
        reqs_left++;
        raster_reqs.push_back(rq);
    endtask

    task automatic settle();
        @(negedge clk);
        while (reqs_left != 0 || expected_px.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_px();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PIX_MAX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] rand_krow();
        logic [KROW_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = 24'h808080;
            1: v = 24'h7F7F7F;
            2: v = 24'hFFFFFF;
            3: v = 24'h000000;
            4:
            begin
                // small taps keep the sum inside 0..255 more often
                for (int k = 0; k < N_TAPS; k++)
                    v[8*k +: 8] = 8'($urandom_range(0, 8) - 4);
            end
            default: v = KROW_W'($urandom);
        endcase
        return v;
    endfunction

    // whole frame from its start, cut short after `cut` requests;
    // now and then an out-of-place request that the block must drop
    task automatic send_frame(int unsigned cut);
        int unsigned w;
        int unsigned pix_total;
        w         = eff_w();
        pix_total = w * eff_h();
        for (int unsigned k = 0; k < pix_total + w && k < cut; k++)
        begin
            if ($urandom_range(0, 31) == 0)
                offer((k < pix_total) ? OP_FLUSH : OP_PIXEL, rand_px());
            offer((k < pix_total) ? OP_PIXEL : OP_FLUSH, rand_px());
            frame_reqs++;
        end
    endtask

    function automatic bit frame_open();
        return row_pos != 0 || col_pos != 0 || drain_pos != 0;
    endfunction

    // complete the frame in progress from the predictor's raster position
    task automatic finish_frame();
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned px_left;
        int unsigned fl_left;
        w = eff_w();
        h = eff_h();
        if (row_pos >= h)
        begin
            px_left = 0;
            fl_left = w - ((drain_pos > w - 1) ? w - 1 : drain_pos);
        end
        else
        begin
            c       = (col_pos > w - 1) ? w - 1 : col_pos;
            px_left = (w - c) + (h - row_pos - 1) * w;
            fl_left = w;
        end
        repeat (px_left) offer(OP_PIXEL, rand_px());
        repeat (fl_left) offer(OP_FLUSH, rand_px());
    endtask

    initial
    begin
        int unsigned start_reqs;
        int unsigned total;

        rst_n           = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_KERNEL_TOP;
        cfg_if.data     = '0;
        for (int k = 0; k < N_TAPS; k++)
            kern_rows[k] = KROW_RESET;
        frame_w   = WIDTH_RESET;
        frame_h   = HEIGHT_RESET;
        win_last  = '0;
        win_prev  = '0;
        row_pos   = 0;
        col_pos   = 0;
        drain_pos = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // 3x2 frame on the reset kernel; early flush and late pixel are dropped
        set_reg(CFG_IMAGE_WIDTH, 3);
        set_reg(CFG_IMAGE_HEIGHT, 2);
        offer(OP_FLUSH, 8'hA5);
        offer(OP_PIXEL, 8'd0);
        offer(OP_PIXEL, 8'd255);
        offer(OP_PIXEL, 8'd128);
        offer(OP_PIXEL, 8'd255);
        offer(OP_PIXEL, 8'd0);
        offer(OP_PIXEL, 8'd37);
        offer(OP_PIXEL, 8'd99);
        repeat (3) offer(OP_FLUSH, 8'h5A);
        settle();

        // zero width and height act as a single pixel frame
        set_reg(CFG_KERNEL_MIDDLE, 24'h007F00);
        set_reg(CFG_IMAGE_WIDTH, 0);
        set_reg(CFG_IMAGE_HEIGHT, 0);
        offer(OP_PIXEL, 8'd255);
        offer(OP_FLUSH, 8'd0);
        offer(OP_PIXEL, 8'd1);
        offer(OP_FLUSH, 8'd255);
        settle();

        // extreme coefficients
        set_reg(CFG_KERNEL_TOP, 24'h808080);
        set_reg(CFG_KERNEL_MIDDLE, 24'h7F7F7F);
        set_reg(CFG_KERNEL_BOTTOM, 24'h7F807F);
        set_reg(CFG_IMAGE_WIDTH, 2);
        set_reg(CFG_IMAGE_HEIGHT, 3);
        offer(OP_PIXEL, 8'd255);
        offer(OP_PIXEL, 8'd0);
        offer(OP_PIXEL, 8'd255);
        offer(OP_PIXEL, 8'd0);
        offer(OP_PIXEL, 8'd255);
        offer(OP_PIXEL, 8'd255);
        repeat (2) offer(OP_FLUSH, 8'd0);
        settle();

        // width beyond the line store clamps to its full length; row cut and narrowed
        set_reg(CFG_KERNEL_TOP, rand_krow());
        set_reg(CFG_KERNEL_MIDDLE, rand_krow());
        set_reg(CFG_KERNEL_BOTTOM, rand_krow());
        set_reg(CFG_IMAGE_WIDTH, 2047);
        set_reg(CFG_IMAGE_HEIGHT, 2);
        send_frame(12);
        settle();
        set_reg(CFG_IMAGE_WIDTH, 4);
        finish_frame();
        settle();

        // tallest frame, one column wide, cut short by lowering the height
        set_reg(CFG_IMAGE_WIDTH, 1);
        set_reg(CFG_IMAGE_HEIGHT, 4095);
        send_frame(24);
        settle();
        set_reg(CFG_IMAGE_HEIGHT, 3);
        finish_frame();
        settle();

        // width cut below the current column mid-row
        set_reg(CFG_KERNEL_MIDDLE, rand_krow());
        set_reg(CFG_IMAGE_WIDTH, 6);
        set_reg(CFG_IMAGE_HEIGHT, 4);
        send_frame(10);
        settle();
        set_reg(CFG_IMAGE_WIDTH, 3);
        finish_frame();
        settle();

        // height cut below the current row: frame counts as received
        set_reg(CFG_IMAGE_WIDTH, 4);
        set_reg(CFG_IMAGE_HEIGHT, 6);
        send_frame(14);
        settle();
        set_reg(CFG_IMAGE_HEIGHT, 2);
        offer(OP_PIXEL, 8'd200);
        finish_frame();
        settle();

        // back-pressure: results held off while requests keep coming
        set_reg(CFG_IMAGE_WIDTH, 8);
        set_reg(CFG_IMAGE_HEIGHT, 6);
        send_frame(32'hFFFF_FFFF);
        hold_ask++;
        settle();

        start_reqs = frame_reqs;
        while (frame_reqs < start_reqs + RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 4) != 0);
            if (frame_open())
            begin
                // only shrink while a frame is open, so every store entry read was written
                if ($urandom_range(0, 1) == 0)
                    set_reg(CFG_KERNEL_MIDDLE, rand_krow());
                if ($urandom_range(0, 2) == 0)
                    set_reg(CFG_IMAGE_WIDTH, KROW_W'($urandom_range(0, eff_w())));
                if ($urandom_range(0, 2) == 0)
                    set_reg(CFG_IMAGE_HEIGHT, KROW_W'($urandom_range(0, eff_h())));
                finish_frame();
                settle();
            end
            if ($urandom_range(0, 1) == 0)
                set_reg(CFG_KERNEL_TOP, rand_krow());
            if ($urandom_range(0, 1) == 0)
                set_reg(CFG_KERNEL_MIDDLE, rand_krow());
            if ($urandom_range(0, 1) == 0)
                set_reg(CFG_KERNEL_BOTTOM, rand_krow());
            set_reg(CFG_IMAGE_WIDTH,
                    KROW_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10)));
            set_reg(CFG_IMAGE_HEIGHT,
                    KROW_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6)));
            total = eff_w() * eff_h() + eff_w();
            repeat ($urandom_range(1, 2)) send_frame(total);
            if ($urandom_range(0, 3) == 0)
                send_frame($urandom_range(1, total));
            settle();
        end

        // tail of the run with no idling on either side
        idle_on = 1'b0;
        if (frame_open())
        begin
            finish_frame();
            settle();
        end
        set_reg(CFG_KERNEL_TOP, rand_krow());
        set_reg(CFG_IMAGE_WIDTH, 5);
        set_reg(CFG_IMAGE_HEIGHT, 4);
        repeat (2) send_frame(32'hFFFF_FFFF);
        settle();

        if (err_count == 0 && expected_px.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
